[rtl/core/lz_backref_stream_decompressor_macros.svh]
// Assertion macros for the LZ back-reference decompressor checker
`ifndef LZ_BACKREF_STREAM_DECOMPRESSOR_MACROS_SVH
`define LZ_BACKREF_STREAM_DECOMPRESSOR_MACROS_SVH
// Assert a property under the active-low asynchronous reset
`define LZD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assert an implication under the active-low asynchronous reset
`define LZD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`endif

[rtl/core/lzd_pkg.sv]
// Package with types and constants of the LZ back-reference decompressor
`timescale 1ns / 1ps
package lzd_pkg;
  localparam int unsigned HistoryDepthDefault = 65536;
  localparam int unsigned CountBitsDefault    = 24;
  localparam int unsigned CfgBits             = 24;

  localparam logic [2:0] StByte     = 3'd0;
  localparam logic [2:0] StEndOk    = 3'd1;
  localparam logic [2:0] StBadDist  = 3'd2;
  localparam logic [2:0] StTrunc    = 3'd3;
  localparam logic [2:0] StSizeErr  = 3'd4;
  localparam logic [2:0] StUnsupp   = 3'd5;

  localparam logic ActByte  = 1'b0;
  localparam logic ActDrain = 1'b1;

  typedef enum logic [10:0] {
    PhFlag    = 11'b00000000001,
    PhNear    = 11'b00000000010,
    PhLenOne  = 11'b00000000100,
    PhLenHi   = 11'b00000001000,
    PhLenLo   = 11'b00000010000,
    PhDistHi  = 11'b00000100000,
    PhDistLo  = 11'b00001000000,
    PhLitLen  = 11'b00010000000,
    PhEndHi   = 11'b00100000000,
    PhEndLo   = 11'b01000000000,
    PhLiteral = 11'b10000000000
  } phase_e;

  typedef struct packed {
    logic       action;
    logic [7:0] comp_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       copy_pending;
    logic       last;
  } out_item_t;

  // Write request from the decoder toward the history memory
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } hist_wr_t;
endpackage

[rtl/core/lzd_history.sv]
// History memory with one write port and one registered read port, plus forwarding
`timescale 1ns / 1ps
module lzd_history #(
  parameter int unsigned AddrBits = 16
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [AddrBits-1:0] wr_addr_i,
  input  logic [7:0]          wr_data_i,
  input  logic                rd_en_i,
  input  logic [AddrBits-1:0] rd_addr_i,
  output logic [7:0]          rd_data_o
);
  logic [7:0] mem_q [2**AddrBits];
  logic [7:0] ram_q;
  logic [7:0] fwd_q;
  logic       fwd_sel_q;

  // Write one byte per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read: the data appears in the cycle after rd_en_i
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      ram_q <= mem_q[rd_addr_i];
    end
  end

  // Forward a same-cycle write to the same address
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_sel_q <= wr_en_i && (wr_addr_i == rd_addr_i);
      fwd_q     <= wr_data_i;
    end
  end

  assign rd_data_o = fwd_sel_q ? fwd_q : ram_q;
endmodule

[rtl/core/lz_backref_stream_decompressor.sv]
// Top level of the byte-serial LZ back-reference decompressor
`timescale 1ns / 1ps
// Usage: the input channel (in_valid_i/in_ready_o/in_item_i) carries one
// transaction per compressed byte (action 0) or per drain tick (action 1).
// The output channel (out_valid_o/out_ready_i/out_item_o) carries zero or one
// result per input transaction: a decoded byte, or an end/error status with
// last set. Literals come out as their bytes arrive; a back-reference loads a
// pending copy that is drained one byte per drain tick.
// The transaction first sits in a history stage that reads a copy byte (one
// read port, registered) or holds a literal for writing, then moves to the
// output register. Throughput: one transaction per cycle while the receiver
// does not stall, set by the one history read and one write per cycle;
// a copy that overlaps its own output is served by forwarding in the memory.
// Reset (rst_ni low) clears the decoder, the byte count and the halted flag;
// history content is undefined until written and needs no clearing pass.
// When the receiver stalls, the output register and the history stage hold
// and in_ready_o stays low until the waiting result is taken.
// The user must write expected_size through cfg_we_i/cfg_wdata_i only
// while idle; the block itself does not enforce it.
module lz_backref_stream_decompressor
  import lzd_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = lzd_pkg::HistoryDepthDefault,
  parameter int unsigned COUNT_BITS    = lzd_pkg::CountBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [23:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lzd_pkg::in_item_t    in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lzd_pkg::out_item_t   out_item_o
);
  localparam int unsigned AddrBits = $clog2(HISTORY_DEPTH);

  logic [CfgBits-1:0]    exp_size_q;
  logic [COUNT_BITS-1:0] count_q, count_d;
  phase_e                phase_q, phase_d;
  logic [7:0]            tok0_q, tok0_d, tok1_q, tok1_d, tok2_q, tok2_d;
  logic [15:0]           copy_rem_q, copy_rem_d;
  logic [15:0]           copy_dist_q, copy_dist_d;
  logic [16:0]           lit_rem_q, lit_rem_d;
  logic                  halted_q, halted_d;

  // Stage 2 (history access) and output register
  logic                  s2_valid_q;
  logic                  s2_copy_q;
  logic                  s2_wr_q;
  logic                  s2_pend_q;
  logic [AddrBits-1:0]   s2_addr_q;
  logic [7:0]            s2_wdata_q;
  out_item_t             s2_res_q;
  logic                  out_valid_q;
  out_item_t             out_q;

  logic                  accept, stall;
  logic                  res_valid;
  out_item_t             res;
  logic                  rd_en;
  logic [AddrBits-1:0]   rd_addr, wr_addr, count_addr;
  hist_wr_t              lit_wr;
  logic [7:0]            rd_data;
  logic                  wr_en;
  logic [7:0]            wr_data;

  // Config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_size_q <= '0;
    end else if (cfg_we_i) begin
      exp_size_q <= cfg_wdata_i;
    end
  end

  // Output side: stage 2 drains into the output register
  assign stall      = out_valid_q && !out_ready_i;
  assign in_ready_o = !stall;
  assign accept     = in_valid_i && in_ready_o;
  assign count_addr = AddrBits'(count_q);

  // Decode one transaction
  always_comb begin
    logic [15:0] v;
    logic [16:0] off;
    logic [16:0] len;
    logic [16:0] ref_dist;
    logic        do_copy;
    logic [2:0]  err;
    logic [4:0]  t;
    count_d     = count_q;
    phase_d     = phase_q;
    tok0_d      = tok0_q;
    tok1_d      = tok1_q;
    tok2_d      = tok2_q;
    copy_rem_d  = copy_rem_q;
    copy_dist_d = copy_dist_q;
    lit_rem_d   = lit_rem_q;
    halted_d    = halted_q;
    res_valid   = 1'b0;
    res         = '0;
    rd_en       = 1'b0;
    rd_addr     = count_addr - AddrBits'(copy_dist_q);
    lit_wr      = '0;
    v           = '0;
    off         = '0;
    len         = '0;
    do_copy     = 1'b0;
    err         = StByte;
    t           = '0;
    ref_dist    = '0;
    if (accept && !halted_q) begin
      if (in_item_i.action == ActDrain) begin
        if (copy_rem_q != '0) begin
          rd_en      = 1'b1;
          count_d    = count_q + 1'b1;
          copy_rem_d = copy_rem_q - 1'b1;
        end
      end else if (copy_rem_q == '0) begin
        unique case (phase_q)
          PhFlag: begin
            tok0_d = in_item_i.comp_byte;
            if (in_item_i.comp_byte >= 8'h40) begin
              phase_d = PhNear;
            end else if (in_item_i.comp_byte >= 8'h10) begin
              t = (in_item_i.comp_byte >= 8'h20) ? in_item_i.comp_byte[4:0]
                                                 : {2'b00, in_item_i.comp_byte[2:0]};
              if (t == 5'd0) begin
                phase_d = PhLenOne;
              end else if (t == 5'd1) begin
                phase_d = PhLenHi;
              end else begin
                lit_rem_d = 17'(t) + 17'd2;
                phase_d   = PhDistHi;
              end
            end else if (in_item_i.comp_byte >= 8'h02) begin
              lit_rem_d = 17'(in_item_i.comp_byte) + 17'd2;
              phase_d   = PhLiteral;
            end else if (in_item_i.comp_byte == 8'h00) begin
              phase_d = PhLitLen;
            end else begin
              phase_d = PhEndHi;
            end
          end
          PhNear: begin
            v       = {tok0_q, in_item_i.comp_byte};
            off     = 17'(v[12:2]);
            len     = 17'(v[15:13]) + 17'd1;
            do_copy = 1'b1;
          end
          PhLenOne: begin
            lit_rem_d = 17'(in_item_i.comp_byte) + ((tok0_q >= 8'h20) ? 17'h22 : 17'hA);
            phase_d   = PhDistHi;
          end
          PhLenHi: begin
            tok1_d  = in_item_i.comp_byte;
            phase_d = PhLenLo;
          end
          PhLenLo: begin
            lit_rem_d = {1'b0, tok1_q, in_item_i.comp_byte};
            phase_d   = PhDistHi;
          end
          PhDistHi: begin
            tok2_d  = in_item_i.comp_byte;
            phase_d = PhDistLo;
          end
          PhDistLo: begin
            off = 17'({tok2_q, in_item_i.comp_byte} >> 2);
            if (tok0_q < 8'h20) begin
              off = off + 17'h4000 + (tok0_q[3] ? 17'h4000 : 17'h0);
            end
            len     = lit_rem_q;
            do_copy = 1'b1;
          end
          PhLitLen: begin
            lit_rem_d = 17'(in_item_i.comp_byte) + 17'h12;
            phase_d   = PhLiteral;
          end
          PhEndHi: begin
            tok1_d  = in_item_i.comp_byte;
            phase_d = PhEndLo;
          end
          PhEndLo: begin
            if ({tok1_q, in_item_i.comp_byte[7:2]} != '0) begin
              err = StUnsupp;
            end else if (32'(count_q) == 32'(exp_size_q)) begin
              err = StEndOk;
            end else begin
              err = StSizeErr;
            end
          end
          PhLiteral: begin
            lit_wr.valid = 1'b1;
            lit_wr.data  = in_item_i.comp_byte;
            count_d      = count_q + 1'b1;
            if (lit_rem_q != '0) begin
              lit_rem_d = lit_rem_q - 1'b1;
            end
            if (lit_rem_q <= 17'd1) begin
              phase_d = PhFlag;
            end
          end
          default: phase_d = PhFlag;
        endcase
        // Start a copy once the reference is complete
        if (do_copy) begin
          ref_dist = off + 17'd1;
          if (len != '0 && 33'(ref_dist) > 33'(count_q)) begin
            err = StBadDist;
          end else begin
            copy_rem_d  = len[15:0];
            copy_dist_d = ref_dist[15:0];
            lit_rem_d   = 17'(in_item_i.comp_byte[1:0]);
            phase_d     = (in_item_i.comp_byte[1:0] != 2'd0) ? PhLiteral : PhFlag;
          end
        end
        // Resolve status precedence
        if (err != StByte) begin
          halted_d   = 1'b1;
          copy_rem_d = '0;
          lit_wr     = '0;
          count_d    = count_q;
          res_valid  = 1'b1;
          res        = '{out_byte: 8'h00, status: err, copy_pending: 1'b0, last: 1'b1};
        end else if (in_item_i.final_byte) begin
          halted_d   = 1'b1;
          copy_rem_d = '0;
          res_valid  = 1'b1;
          res        = '{out_byte: 8'h00, status: StTrunc, copy_pending: 1'b0, last: 1'b1};
        end else if (lit_wr.valid) begin
          res_valid = 1'b1;
          res       = '{out_byte: in_item_i.comp_byte, status: StByte,
                        copy_pending: (copy_rem_d != '0), last: 1'b0};
        end
      end
    end
  end

  // Advance decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      phase_q     <= PhFlag;
      tok0_q      <= '0;
      tok1_q      <= '0;
      tok2_q      <= '0;
      copy_rem_q  <= '0;
      copy_dist_q <= '0;
      lit_rem_q   <= '0;
      halted_q    <= 1'b0;
    end else begin
      count_q     <= count_d;
      phase_q     <= phase_d;
      tok0_q      <= tok0_d;
      tok1_q      <= tok1_d;
      tok2_q      <= tok2_d;
      copy_rem_q  <= copy_rem_d;
      copy_dist_q <= copy_dist_d;
      lit_rem_q   <= lit_rem_d;
      halted_q    <= halted_d;
    end
  end

  // History write from stage 2: a copied byte or a literal, in stream order
  assign wr_en   = s2_wr_q && !stall;
  assign wr_data = s2_copy_q ? rd_data : s2_wdata_q;
  assign wr_addr = s2_addr_q;

  lzd_history #(
    .AddrBits (AddrBits)
  ) u_history (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Stage 2 holds a copy read or a decoded result; hold it while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s2_copy_q  <= 1'b0;
      s2_wr_q    <= 1'b0;
      s2_pend_q  <= 1'b0;
    end else if (!stall) begin
      s2_valid_q <= rd_en || res_valid;
      s2_copy_q  <= rd_en;
      s2_wr_q    <= rd_en || lit_wr.valid;
      s2_pend_q  <= (copy_rem_d != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      s2_addr_q  <= count_addr;
      s2_wdata_q <= lit_wr.data;
      s2_res_q   <= res;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!stall) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      if (s2_copy_q) begin
        out_q <= '{out_byte: rd_data, status: StByte, copy_pending: s2_pend_q, last: 1'b0};
      end else begin
        out_q <= s2_res_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
endmodule

[rtl/core/lzd_checker.sv]
// Port-level checker for the LZ back-reference decompressor, with its bind
`timescale 1ns / 1ps
`include "lz_backref_stream_decompressor_macros.svh"
module lzd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input lzd_pkg::out_item_t out_item_o
);
  import lzd_pkg::*;
  `LZD_ASSERT_IMP(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, ##1 out_valid_o && $stable(out_item_o), "output dropped under stall")
  `LZD_ASSERT_IMP(a_last_status, clk_i, rst_ni, out_valid_o && out_item_o.last, out_item_o.status != StByte && out_item_o.out_byte == 8'h00, "last result without status")
  `LZD_ASSERT_IMP(a_byte_not_last, clk_i, rst_ni, out_valid_o && out_item_o.status == StByte, !out_item_o.last, "byte result marked last")
  `LZD_ASSERT_IMP(a_status_range, clk_i, rst_ni, out_valid_o, out_item_o.status <= StUnsupp, "status out of range")
  `LZD_ASSERT_IMP(a_stall_blocks_in, clk_i, rst_ni, out_valid_o && !out_ready_i, !in_ready_o, "input taken while output stalled")
endmodule

bind lz_backref_stream_decompressor lzd_checker u_lzd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

[test/lz_backref_stream_decompressor_test.sv]
// Testbench for the byte-serial LZ back-reference decompressor
`timescale 1ns / 1ps
module lz_backref_stream_decompressor_test;
  import lzd_pkg::*;

  localparam int unsigned IdleLimit = 2000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [23:0] cfg_wdata_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  in_item_t   in_item_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_item_t  out_item_o;

  lz_backref_stream_decompressor dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always #1 clk_i = ~clk_i;

  // Decoder state as predicted from the accepted transactions
  logic [7:0]  hist_mem [0:65535];
  logic [23:0] byte_count = '0;
  phase_e      dec_phase = PhFlag;
  logic [7:0]  flag_byte = '0, len_hi_byte = '0, dist_hi_byte = '0;
  logic [15:0] copy_left = '0, copy_dist = '0;
  logic [31:0] run_left = '0;
  bit          stream_halted = 1'b0;
  logic [23:0] size_reg = '0;

  out_item_t   expected_results[$];
  int unsigned fail_cnt = 0, sent_cnt = 0, result_cnt = 0, copy_cnt = 0;
  int unsigned quiet_cycles = 0;
  bit          no_idle = 1'b0;
  int unsigned stall_left = 0;

  initial begin
    for (int i = 0; i < 65536; i++) hist_mem[i] = 8'h00;
  end

  function automatic int unsigned pick_delay();
    int unsigned r;
    r = $urandom_range(99);
    if (no_idle || r < 65) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic void put_history(logic [7:0] b);
    hist_mem[byte_count[15:0]] = b;
    byte_count = byte_count + 24'd1;
  endfunction

  // Load a copy, or return a bad-distance status when it reaches behind the start
  function automatic logic [2:0] load_copy(logic [31:0] off, logic [31:0] len,
                                           logic [1:0] trail);
    logic [31:0] ref_dist;
    ref_dist = off + 32'd1;
    if (len != 0 && ref_dist > {8'd0, byte_count}) return StBadDist;
    copy_left = len[15:0];
    copy_dist = ref_dist[15:0];
    run_left  = {30'd0, trail};
    dec_phase = (trail != 0) ? PhLiteral : PhFlag;
    return StByte;
  endfunction

  // Advance the predicted decoder by one transaction
  function automatic bit decode_step(in_item_t it, output out_item_t r);
    logic [7:0]  b, t, v8;
    logic [15:0] v, src;
    logic [31:0] off;
    logic [2:0]  st;
    bit          emitted;
    b = it.comp_byte;
    st = StByte;
    emitted = 1'b0;
    r = '0;
    if (stream_halted) return 1'b0;
    if (it.action == ActDrain) begin
      if (copy_left == 0) return 1'b0;
      src = byte_count[15:0] - copy_dist;
      v8 = hist_mem[src];
      put_history(v8);
      copy_left = copy_left - 16'd1;
      r = '{out_byte: v8, status: StByte, copy_pending: copy_left != 0, last: 1'b0};
      return 1'b1;
    end
    if (copy_left != 0) return 1'b0;
    case (dec_phase)
      PhFlag: begin
        flag_byte = b;
        if (b >= 8'h40) begin
          dec_phase = PhNear;
        end else if (b >= 8'h10) begin
          t = (b >= 8'h20) ? (b & 8'h1F) : (b & 8'h07);
          if (t == 0) dec_phase = PhLenOne;
          else if (t == 1) dec_phase = PhLenHi;
          else begin
            copy_left = '0;
            run_left = t + 32'd2;
            dec_phase = PhDistHi;
          end
        end else if (b >= 8'h02) begin
          run_left = b + 32'd2;
          dec_phase = PhLiteral;
        end else if (b == 8'h00) begin
          dec_phase = PhLitLen;
        end else begin
          dec_phase = PhEndHi;
        end
      end
      PhNear: begin
        v = {flag_byte, b};
        st = load_copy({21'd0, v[12:2]}, {29'd0, v[15:13]} + 32'd1, b[1:0]);
      end
      PhLenOne: begin
        run_left = b + ((flag_byte >= 8'h20) ? 32'h22 : 32'hA);
        dec_phase = PhDistHi;
      end
      PhLenHi: begin
        len_hi_byte = b;
        dec_phase = PhLenLo;
      end
      PhLenLo: begin
        run_left = {16'd0, len_hi_byte, b};
        dec_phase = PhDistHi;
      end
      PhDistHi: begin
        dist_hi_byte = b;
        dec_phase = PhDistLo;
      end
      PhDistLo: begin
        off = {18'd0, dist_hi_byte, b[7:2]};
        if (flag_byte < 8'h20) begin
          off = off + 32'h4000;
          if (flag_byte[3]) off = off + 32'h4000;
        end
        st = load_copy(off, run_left, b[1:0]);
      end
      PhLitLen: begin
        run_left = b + 32'h12;
        dec_phase = PhLiteral;
      end
      PhEndHi: begin
        len_hi_byte = b;
        dec_phase = PhEndLo;
      end
      PhEndLo: begin
        v = {len_hi_byte, b};
        if (v[15:2] != 0) st = StUnsupp;
        else st = (byte_count == size_reg) ? StEndOk : StSizeErr;
      end
      default: begin
        put_history(b);
        emitted = 1'b1;
        if (run_left != 0) run_left = run_left - 1;
        if (run_left == 0) dec_phase = PhFlag;
      end
    endcase
    if (st != StByte || it.final_byte) begin
      stream_halted = 1'b1;
      copy_left = '0;
      r = '{out_byte: 8'd0, status: (st != StByte) ? st : StTrunc,
            copy_pending: 1'b0, last: 1'b1};
      return 1'b1;
    end
    if (emitted) begin
      r = '{out_byte: b, status: StByte, copy_pending: 1'b0, last: 1'b0};
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Send one transaction, predict its result, then possibly idle for a while
  task automatic send_item(logic act, logic [7:0] b, logic fin);
    in_item_t  it;
    out_item_t r;
    int unsigned gap;
    it = '{action: act, comp_byte: b, final_byte: fin};
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_cnt++;
    if (decode_step(it, r)) expected_results.push_back(r);
    gap = pick_delay();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(ActByte, b, 1'b0);
  endtask

  // Drop valid, wait for every result and let the pipeline settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_size(logic [23:0] val);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    size_reg = val;
  endtask

  // Drain the pending copy (with stray bytes now and then), then the trailing literals
  task automatic finish_token();
    while (copy_left != 0) begin
      if ($urandom_range(9) == 0)
        send_item(ActByte, 8'($urandom), 1'($urandom));
      send_item(ActDrain, 8'($urandom), 1'($urandom));
    end
    while (dec_phase == PhLiteral) send_byte(8'($urandom));
  endtask

  task automatic literal_run(int unsigned n);
    send_byte(8'(n - 2));
    finish_token();
  endtask

  task automatic long_literal_run(logic [7:0] lb);
    send_byte(8'h00);
    send_byte(lb);
    finish_token();
  endtask

  // Near reference: len 3..8, 11-bit offset
  task automatic near_ref(int unsigned len, int unsigned off, logic [1:0] trail);
    copy_cnt++;
    send_byte(8'(((len - 1) << 5) | (off >> 6)));
    send_byte(8'(((off & 63) << 2) | trail));
    finish_token();
  endtask

  // Mid or far reference; mode 0 short length, 1 length byte, 2 two-byte length
  task automatic wide_ref(logic [7:0] base, int unsigned mode, int unsigned len,
                          int unsigned off, logic [1:0] trail);
    copy_cnt++;
    case (mode)
      0: send_byte(base | 8'(len - 2));
      1: begin
        send_byte(base);
        send_byte(8'(len - ((base >= 8'h20) ? 32'h22 : 32'hA)));
      end
      default: begin
        send_byte(base | 8'h01);
        send_byte(8'(len >> 8));
        send_byte(8'(len));
      end
    endcase
    send_byte(8'(off >> 6));
    send_byte(8'(((off & 63) << 2) | trail));
    finish_token();
  endtask

  function automatic int unsigned pick_offset(int unsigned max_off);
    int unsigned top;
    top = byte_count - 1;
    if (top > max_off) top = max_off;
    if ($urandom_range(3) == 0) return $urandom_range(top < 3 ? top : 3, 0);
    return $urandom_range(top, 0);
  endfunction

  task automatic test_directed();
    write_size(24'hFFFFFF);
    send_item(ActDrain, 8'h00, 1'b0);
    literal_run(4);
    send_byte(8'h03);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    send_byte(8'h5A);
    send_byte(8'h0F);
    near_ref(8, 0, 2'd0);
    near_ref(3, byte_count - 1, 2'd3);
    wide_ref(8'h20, 2, 0, 16383, 2'd1);
    wide_ref(8'h18, 2, 0, 9, 2'd2);
    wide_ref(8'h20, 0, 4, byte_count - 1, 2'd0);
  endtask

  task automatic test_config();
    write_size(24'h000000);
    write_size(24'($urandom));
  endtask

  task automatic test_random_stream(int unsigned target);
    int unsigned k, len;
    while (sent_cnt < target) begin
      no_idle = ($urandom_range(7) == 0);
      k = $urandom_range(99);
      if (k < 25) literal_run($urandom_range(17, 4));
      else if (k < 32) long_literal_run(8'($urandom_range(12)));
      else if (k < 36) long_literal_run(8'($urandom_range(255, 240)));
      else if (k < 60) near_ref($urandom_range(8, 3), pick_offset(2047), 2'($urandom));
      else if (k < 80) begin
        len = $urandom_range(2) == 2 ? $urandom_range(40, 0) : $urandom_range(33, 4);
        case ($urandom_range(2))
          0: wide_ref(8'h20, 0, $urandom_range(33, 4), pick_offset(16383), 2'($urandom));
          1: wide_ref(8'h20, 1, $urandom_range(0, 6) + 34, pick_offset(16383),
                      2'($urandom));
          default: wide_ref(8'h20, 2, len, len == 0 ? $urandom_range(16383) :
                            pick_offset(16383), 2'($urandom));
        endcase
      end else if (k < 86) begin
        wide_ref($urandom_range(1) ? 8'h18 : 8'h10, 2, 0, $urandom_range(16383),
                 2'($urandom));
      end else if (k < 92) begin
        send_item(ActDrain, 8'($urandom), 1'($urandom));
      end else if (k < 95) begin
        // hold off the next token until all results are out
        wait_idle();
      end else begin
        near_ref($urandom_range(8, 3), pick_offset(2047), 2'($urandom));
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic test_end_marker();
    write_size(byte_count);
    send_byte(8'h01);
    send_byte(8'h00);
    send_item(ActByte, 8'($urandom_range(3)), 1'b1);
    // the stream is halted now: nothing more may come out
    send_byte(8'h05);
    send_item(ActDrain, 8'hFF, 1'b1);
  endtask

  // Random receiver stalls; compare each result against the oldest prediction
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      stall_left = no_idle ? 0 : pick_delay();
      out_ready_i <= (stall_left == 0);
    end
    if (out_valid_o && out_ready_i) begin
      result_cnt++;
      if (expected_results.size() == 0) begin
        $error("unexpected result %p", out_item_o);
        fail_cnt++;
      end else begin
        out_item_t e;
        e = expected_results.pop_front();
        if (out_item_o.out_byte !== e.out_byte) begin
          $error("out_byte expected %0h actual %0h", e.out_byte, out_item_o.out_byte);
          fail_cnt++;
        end
        if (out_item_o.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_item_o.status);
          fail_cnt++;
        end
        if (out_item_o.copy_pending !== e.copy_pending) begin
          $error("copy_pending expected %0b actual %0b", e.copy_pending,
                 out_item_o.copy_pending);
          fail_cnt++;
        end
        if (out_item_o.last !== e.last) begin
          $error("last expected %0b actual %0b", e.last, out_item_o.last);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config();
    test_random_stream(300);
    test_config();
    test_random_stream(560);
    test_end_marker();
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      fail_cnt++;
    end
    $display("Sent %0d transactions (%0d references), checked %0d results,",
             sent_cnt, copy_cnt, result_cnt);
    $display("%0d bytes rebuilt, stream closed by end marker", byte_count);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/lzd_pkg.sv
rtl/core/lzd_history.sv
rtl/core/lz_backref_stream_decompressor.sv
rtl/core/lzd_checker.sv
test/lz_backref_stream_decompressor_test.sv
